// File: rtl/crc_pkg.sv
// Shared types, constants and helpers for the circle raster engine.
// Depends on nothing; every other file in rtl imports it.
// Board size, radius limit and field widths live here.
package crc_pkg;

  localparam int BOARD_WIDTH  = 64;
  localparam int BOARD_HEIGHT = 64;
  localparam int MAX_RADIUS   = 127;
  localparam int CELL_COUNT   = BOARD_WIDTH * BOARD_HEIGHT;

  localparam int COL_W   = 6;
  localparam int ROW_W   = 6;
  localparam int RAD_W   = 7;
  localparam int INK_W   = 8;
  localparam int CELL_W  = 8;
  localparam int CMD_W   = 2;
  localparam int CFG_W   = 8;
  localparam int IDX_W   = 3;
  localparam int ADDR_W  = $clog2(CELL_COUNT);
  localparam int SQ_W    = 2 * COL_W;
  localparam int DIST_W  = SQ_W + 1;
  localparam int RR_W    = 2 * RAD_W + 1;
  localparam int SPAN_W  = RAD_W + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_DRAW = 2'd0,
    CMD_READ = 2'd1,
    CMD_TEST = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [IDX_W-1:0] REG_CENTER_COL = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_ROW = 3'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS     = 3'd2;
  localparam logic [IDX_W-1:0] REG_FILL_MODE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_INK        = 3'd4;

  typedef struct packed {
    logic [COL_W-1:0] cx;
    logic [ROW_W-1:0] cy;
    logic [RAD_W-1:0] r;
    logic             fill;
  } shape_cfg_t;

  typedef struct packed {
    logic             valid;
    logic             draw;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } shape_req_t;

  typedef struct packed {
    logic             valid;
    logic             draw;
    logic             hit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } shape_res_t;

  function automatic logic [RAD_W-1:0] eff_radius(input logic [RAD_W-1:0] r);
    logic [RAD_W:0] lim;
    lim = (RAD_W+1)'(MAX_RADIUS);
    if ({1'b0, r} > lim) return lim[RAD_W-1:0];
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * BOARD_WIDTH + ADDR_W'(col));
  endfunction

endpackage

// File: rtl/crc_board.sv
// Board memory: one write port, one registered read port, and the
// clearing sweep that zeroes every cell after reset.
// Depends on crc_pkg.
module crc_board (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [crc_pkg::ADDR_W-1:0] wr_addr,
  input  logic [crc_pkg::CELL_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [crc_pkg::ADDR_W-1:0] rd_addr,
  output logic [crc_pkg::CELL_W-1:0] rd_data,
  output logic                       clearing
);
  import crc_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(CELL_COUNT - 1)) clearing <= 1'b0;
    end
  end

  // The sweep owns the write port until every cell has been zeroed.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/crc_shape.sv
// Two-stage distance test: squares of the offsets, then the ring or
// disc compare against the squared radius.  Depends on crc_pkg.
module crc_shape (
  input  logic                clk,
  input  logic                rst,
  input  crc_pkg::shape_cfg_t cfg,
  input  crc_pkg::shape_req_t req,
  output crc_pkg::shape_res_t res
);
  import crc_pkg::*;

  logic [RAD_W-1:0]        r;
  logic signed [COL_W+1:0] dx;
  logic signed [ROW_W+1:0] dy;
  logic [COL_W+1:0]        adx_full;
  logic [ROW_W+1:0]        ady_full;
  logic [COL_W-1:0]        adx;
  logic [ROW_W-1:0]        ady;
  logic                    box;

  logic             b_valid;
  logic             b_draw;
  logic             b_box;
  logic [ROW_W-1:0] b_row;
  logic [COL_W-1:0] b_col;
  logic [SQ_W-1:0]  sqx;
  logic [SQ_W-1:0]  sqy;

  logic [RR_W-1:0]   rr;
  logic [RR_W-1:0]   rr_lo;
  logic [RR_W-1:0]   rr_hi;
  logic [DIST_W-1:0] dsum;
  logic [RR_W-1:0]   dist_x;
  logic              rule;

  assign r  = eff_radius(cfg.r);
  assign dx = $signed((COL_W+2)'(req.col)) - $signed((COL_W+2)'(cfg.cx));
  assign dy = $signed((ROW_W+2)'(req.row)) - $signed((ROW_W+2)'(cfg.cy));
  assign adx_full = dx[COL_W+1] ? (COL_W+2)'(-dx) : (COL_W+2)'(dx);
  assign ady_full = dy[ROW_W+1] ? (ROW_W+2)'(-dy) : (ROW_W+2)'(dy);
  // Both ends lie on the board, so the magnitude fits the coordinate width.
  assign adx = adx_full[COL_W-1:0];
  assign ady = ady_full[ROW_W-1:0];
  assign box = (RAD_W'(adx) <= r) && (RAD_W'(ady) <= r);

  // The squared radius and its band edges are registered from the radius; the
  // edges are taken from the registered square, so they settle after it.
  always_ff @(posedge clk) begin
    rr    <= RR_W'(r) * RR_W'(r);
    rr_lo <= rr - RR_W'(r);
    rr_hi <= rr + RR_W'(r);
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else     b_valid <= req.valid;
  end

  always_ff @(posedge clk) begin
    b_draw <= req.draw;
    b_box  <= box;
    b_row  <= req.row;
    b_col  <= req.col;
    sqx    <= SQ_W'(adx) * SQ_W'(adx);
    sqy    <= SQ_W'(ady) * SQ_W'(ady);
  end

  assign dsum   = DIST_W'(sqx) + DIST_W'(sqy);
  assign dist_x = RR_W'(dsum);
  assign rule   = cfg.fill ? (dist_x <= rr) : ((dist_x >= rr_lo) && (dist_x <= rr_hi));

  always_comb begin
    res.valid = b_valid;
    res.draw  = b_draw;
    res.hit   = b_box && rule;
    res.row   = b_row;
    res.col   = b_col;
  end

endmodule

// File: rtl/circle_raster_engine_core.sv
// Top level of the circle raster engine: command sequencer, register
// file, output register, board memory and distance pipeline.
// Depends on crc_pkg, crc_board and crc_shape.
//
//   channel  direction  handshake               payload
//   in       request    in_valid / in_ready     command, query_col, query_row
//   out      result     out_valid / out_ready   cell_value, covered
//   cfg      write      cfg_we                  cfg_index, cfg_data
//
// A draw sweeps the clipped box around the centre, one cell a cycle.
// After reset a clearing pass zeroes the board; in_ready stays low
// meanwhile, while register writes are taken as ever.
// A finished result waits in the output register; the next request is
// accepted while it waits.
module circle_raster_engine_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [crc_pkg::CMD_W-1:0]  command,
  input  logic [crc_pkg::COL_W-1:0]  query_col,
  input  logic [crc_pkg::ROW_W-1:0]  query_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [crc_pkg::CELL_W-1:0] cell_value,
  output logic                       covered,
  input  logic                       cfg_we,
  input  logic [crc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [crc_pkg::CFG_W-1:0]  cfg_data
);
  import crc_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_RUN    = 5'b00100,
    S_READ   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state;

  logic [COL_W-1:0] center_col;
  logic [ROW_W-1:0] center_row;
  logic [RAD_W-1:0] radius;
  logic             fill_mode;
  logic [INK_W-1:0] ink;

  logic             pos_valid;
  logic             is_draw;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col0;
  logic [COL_W-1:0] col1;
  logic [ROW_W-1:0] row1;
  logic             last_pos;

  logic [CELL_W-1:0] res_value;
  logic              res_cov;

  logic                     accept;
  cmd_t                     cmd;
  logic [RAD_W-1:0]         r_eff;
  logic signed [SPAN_W-1:0] row_lo;
  logic signed [SPAN_W-1:0] row_hi;
  logic signed [SPAN_W-1:0] col_lo;
  logic signed [SPAN_W-1:0] col_hi;
  logic [ROW_W-1:0]         row0_c;
  logic [ROW_W-1:0]         row1_c;
  logic [COL_W-1:0]         col0_c;
  logic [COL_W-1:0]         col1_c;

  shape_cfg_t shp_cfg;
  shape_req_t shp_req;
  shape_res_t shp_res;

  logic              mem_wr_en;
  logic [CELL_W-1:0] mem_rd_data;
  logic              clearing;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cmd      = cmd_t'(command);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col <= '0;
      center_row <= '0;
      radius     <= '0;
      fill_mode  <= 1'b0;
      ink        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_COL: center_col <= cfg_data[COL_W-1:0];
        REG_CENTER_ROW: center_row <= cfg_data[ROW_W-1:0];
        REG_RADIUS:     radius     <= cfg_data[RAD_W-1:0];
        REG_FILL_MODE:  fill_mode  <= cfg_data[0];
        REG_INK:        ink        <= cfg_data[INK_W-1:0];
        default: ;
      endcase
    end
  end

  // Sweep box of the draw, clipped to the board edges.
  assign r_eff  = eff_radius(radius);
  assign row_lo = $signed(SPAN_W'(center_row)) - $signed(SPAN_W'(r_eff));
  assign row_hi = $signed(SPAN_W'(center_row)) + $signed(SPAN_W'(r_eff));
  assign col_lo = $signed(SPAN_W'(center_col)) - $signed(SPAN_W'(r_eff));
  assign col_hi = $signed(SPAN_W'(center_col)) + $signed(SPAN_W'(r_eff));
  assign row0_c = (row_lo < 0) ? '0 : ROW_W'(row_lo);
  assign col0_c = (col_lo < 0) ? '0 : COL_W'(col_lo);
  assign row1_c = (row_hi > $signed(SPAN_W'(BOARD_HEIGHT - 1))) ?
                  ROW_W'(BOARD_HEIGHT - 1) : ROW_W'(row_hi);
  assign col1_c = (col_hi > $signed(SPAN_W'(BOARD_WIDTH - 1))) ?
                  COL_W'(BOARD_WIDTH - 1) : COL_W'(col_hi);

  assign last_pos = (col == col1) && (row == row1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pos_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_RESULT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (!clearing) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_DRAW: begin
                state     <= S_RUN;
                pos_valid <= 1'b1;
              end
              CMD_TEST: begin
                state     <= S_RUN;
                pos_valid <= 1'b1;
              end
              CMD_READ: state <= S_READ;
              default:  state <= S_RESULT;
            endcase
          end
        end
        S_RUN: begin
          if (pos_valid && last_pos) pos_valid <= 1'b0;
          if (!pos_valid && !shp_res.valid) state <= S_RESULT;
        end
        S_READ: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_value <= '0;
      res_cov   <= 1'b0;
      is_draw   <= (cmd == CMD_DRAW);
      if (cmd == CMD_DRAW) begin
        row  <= row0_c;
        col  <= col0_c;
        col0 <= col0_c;
        col1 <= col1_c;
        row1 <= row1_c;
      end else begin
        // A test runs the same pipeline over a sweep of a single cell.
        row  <= query_row;
        col  <= query_col;
        col0 <= query_col;
        col1 <= query_col;
        row1 <= query_row;
      end
    end else begin
      if (state == S_RUN && pos_valid && !last_pos) begin
        if (col == col1) begin
          col <= col0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      if (state == S_READ) res_value <= mem_rd_data;
      if (shp_res.valid && !shp_res.draw) res_cov <= shp_res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && (!out_valid || out_ready)) begin
      cell_value <= res_value;
      covered    <= res_cov;
    end
  end

  always_comb begin
    shp_cfg.cx   = center_col;
    shp_cfg.cy   = center_row;
    shp_cfg.r    = radius;
    shp_cfg.fill = fill_mode;
    shp_req.valid = pos_valid;
    shp_req.draw  = is_draw;
    shp_req.row   = row;
    shp_req.col   = col;
  end

  crc_shape u_shape (
    .clk (clk),
    .rst (rst),
    .cfg (shp_cfg),
    .req (shp_req),
    .res (shp_res)
  );

  assign mem_wr_en = shp_res.valid && shp_res.draw && shp_res.hit;

  crc_board u_board (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (mem_wr_en),
    .wr_addr  (cell_addr(shp_res.row, shp_res.col)),
    .wr_data  (ink),
    .rd_en    (accept),
    .rd_addr  (cell_addr(query_row, query_col)),
    .rd_data  (mem_rd_data),
    .clearing (clearing)
  );

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state is not one-hot");

  a_pipe_only_in_run: assert property (@(posedge clk) disable iff (rst)
    shp_res.valid |-> (state == S_RUN))
    else $error("distance pipeline active outside a draw or test");

  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!in_ready && !pos_valid))
    else $error("request taken before the board was cleared");

  a_result_after_result_state: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && $past(!out_valid) && !$past(rst)) ##1 out_valid
      |-> $past(state == S_RESULT))
    else $error("result appeared without passing the result state");

endmodule
